[hdl/tpa_pkg.sv]
package tpa_pkg;

  // primitive modes; the unused code falls back to triangle list
  localparam logic [1:0] MODE_LIST  = 2'd0;
  localparam logic [1:0] MODE_STRIP = 2'd1;
  localparam logic [1:0] MODE_FAN   = 2'd2;

  // register indexes of the configuration port
  localparam logic [1:0] REG_MODE         = 2'd0;
  localparam logic [1:0] REG_REVERSE      = 2'd1;
  localparam logic [1:0] REG_VERTEX_COUNT = 2'd2;
  localparam logic [1:0] REG_BASE_VERTEX  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_RANGE      = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;

  // kind of a queued command
  localparam logic CMD_TRI = 1'b0;
  localparam logic CMD_ERR = 1'b1;

  localparam int DATA_WIDTH = 32;

  typedef struct packed {
    logic [1:0]            mode;
    logic                  reverse;
    logic [DATA_WIDTH-1:0] vertex_count;
    logic [DATA_WIDTH-1:0] base_vertex;
  } tpa_cfg_t;

endpackage

[hdl/tpa_queue.sv]
module tpa_queue #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign head_data = slots[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow : assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");

endmodule

[hdl/tpa_front.sv]
module tpa_front #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tpa_pkg::tpa_cfg_t      cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            in_index,
  input  logic                   in_end,
  input  logic                   q_full,
  output logic                   push,
  output logic [3*INDEX_WIDTH:0] push_data
);
  import tpa_pkg::*;

  localparam int IW = INDEX_WIDTH;

  logic [IW-1:0] fan_anchor, fan_anchor_next;
  logic [IW-1:0] older_index, older_index_next;
  logic [IW-1:0] newer_index, newer_index_next;
  logic [1:0]    seen_count, seen_count_next;
  logic [1:0]    triple_phase, triple_phase_next;
  logic          strip_parity, strip_parity_next;

  logic          accept;
  logic [IW-1:0] idx;
  logic          emit;
  logic          whole;
  logic [IW-1:0] ca, cb, cc;
  logic [IW-1:0] sb, sc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign idx      = in_index[IW-1:0];

  // classify the item and advance the run state
  always_comb begin
    fan_anchor_next   = fan_anchor;
    older_index_next  = older_index;
    newer_index_next  = newer_index;
    triple_phase_next = triple_phase;
    strip_parity_next = strip_parity;
    seen_count_next   = (seen_count == 2'd3) ? seen_count : seen_count + 2'd1;
    emit  = 1'b0;
    whole = 1'b0;
    ca    = older_index;
    cb    = newer_index;
    cc    = idx;
    case (cfg.mode)
      MODE_STRIP: begin
        if (seen_count == 2'd0) begin
          older_index_next = idx;
        end else if (seen_count == 2'd1) begin
          newer_index_next = idx;
        end else begin
          emit = 1'b1;
          if (strip_parity) begin
            ca = newer_index;
            cb = older_index;
          end
          older_index_next  = newer_index;
          newer_index_next  = idx;
          strip_parity_next = !strip_parity;
        end
        whole = (seen_count_next == 2'd3);
      end
      MODE_FAN: begin
        if (seen_count == 2'd0) begin
          fan_anchor_next = idx;
        end else if (seen_count == 2'd1) begin
          newer_index_next = idx;
        end else begin
          emit = 1'b1;
          ca   = fan_anchor;
          newer_index_next = idx;
        end
        whole = (seen_count_next == 2'd3);
      end
      default: begin
        if (triple_phase == 2'd0) begin
          older_index_next  = idx;
          triple_phase_next = 2'd1;
        end else if (triple_phase == 2'd1) begin
          newer_index_next  = idx;
          triple_phase_next = 2'd2;
        end else begin
          emit = 1'b1;
          triple_phase_next = 2'd0;
        end
        whole = (triple_phase_next == 2'd0);
      end
    endcase
  end

  // reverse winding swaps the second and third corners
  assign sb = cfg.reverse ? cc : cb;
  assign sc = cfg.reverse ? cb : cc;

  // one command per triangle, or one error for an incomplete run
  always_comb begin
    push      = 1'b0;
    push_data = {CMD_TRI, sc, sb, ca};
    if (accept) begin
      if (in_end && !whole) begin
        push      = 1'b1;
        push_data = {CMD_ERR, sc, sb, ca};
      end else if (emit) begin
        push = 1'b1;
      end
    end
  end

  // run state, cleared after the run's last item
  always_ff @(posedge clk) begin
    if (rst) begin
      fan_anchor   <= '0;
      older_index  <= '0;
      newer_index  <= '0;
      seen_count   <= '0;
      triple_phase <= '0;
      strip_parity <= 1'b0;
    end else if (accept) begin
      if (in_end) begin
        fan_anchor   <= '0;
        older_index  <= '0;
        newer_index  <= '0;
        seen_count   <= '0;
        triple_phase <= '0;
        strip_parity <= 1'b0;
      end else begin
        fan_anchor   <= fan_anchor_next;
        older_index  <= older_index_next;
        newer_index  <= newer_index_next;
        seen_count   <= seen_count_next;
        triple_phase <= triple_phase_next;
        strip_parity <= strip_parity_next;
      end
    end
  end

  a_push_needs_accept : assert property (@(posedge clk) disable iff (rst)
      push |-> accept)
    else $error("command pushed without an accepted item");
  a_run_restart : assert property (@(posedge clk) disable iff (rst)
      (accept && in_end) |=> (seen_count == 2'd0 && triple_phase == 2'd0))
    else $error("run state not cleared after run end");
  a_phase_range : assert property (@(posedge clk) disable iff (rst)
      triple_phase != 2'd3)
    else $error("list phase out of range");

endmodule

[hdl/tpa_back.sv]
module tpa_back #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tpa_pkg::tpa_cfg_t      cfg,
  input  logic                   q_empty,
  input  logic [3*INDEX_WIDTH:0] head_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            out_vertex,
  output logic [1:0]             out_corner,
  output logic [1:0]             out_status,
  output logic                   out_last
);
  import tpa_pkg::*;

  localparam int IW = INDEX_WIDTH;

  logic          kind;
  logic [IW-1:0] ha, hb, hc;
  logic [IW-1:0] local_idx;
  logic [31:0]   local_ext;
  logic [1:0]    corner;
  logic          load;
  logic          done;

  assign {kind, hc, hb, ha} = head_data;

  assign load      = !q_empty && (!out_valid || out_ready);
  assign done      = (kind == CMD_ERR) || (corner == 2'd2);
  assign pop       = load && done;
  assign local_ext = 32'(local_idx);

  // corner select
  always_comb begin
    case (corner)
      2'd0:    local_idx = ha;
      2'd1:    local_idx = hb;
      default: local_idx = hc;
    endcase
  end

  // corner sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      corner    <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        corner <= done ? 2'd0 : corner + 2'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (kind == CMD_ERR) begin
        out_vertex <= '0;
        out_corner <= 2'd0;
        out_status <= ST_INCOMPLETE;
        out_last   <= 1'b1;
      end else begin
        out_vertex <= cfg.base_vertex + local_ext;
        out_corner <= corner;
        out_status <= (local_ext < cfg.vertex_count) ? ST_OK : ST_RANGE;
        out_last   <= (corner == 2'd2);
      end
    end
  end

  a_corner_range : assert property (@(posedge clk) disable iff (rst) corner != 2'd3)
    else $error("corner counter out of range");
  a_err_single : assert property (@(posedge clk) disable iff (rst)
      (load && kind == CMD_ERR) |-> (corner == 2'd0))
    else $error("error command started mid triangle");
  a_last_status : assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_status == ST_INCOMPLETE) |-> (out_last && out_corner == 2'd0))
    else $error("error result not a single-item burst");

endmodule

[hdl/triangle_primitive_assembler_top.sv]
// a closing item's command is queued, then its first corner goes to the output register
// throughput: one result item per cycle while m_axis_tready is high and the queue
//   is not empty; a closed triangle gives three result items, one per corner
// a two-entry command queue sits between the input classifier and the corner sequencer
// reset: rst (synchronous) clears the registers, the run state, the queue and the output
module triangle_primitive_assembler_top #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // run_index[31:0]
  input  logic        s_axis_tlast,   // run_end
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // vertex_index[31:0], corner[33:32], zeros above
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast    // burst_last
);
  import tpa_pkg::*;

  localparam int CMD_W = 3 * INDEX_WIDTH + 1;

  tpa_cfg_t         cfg;
  logic             q_push, q_pop, q_full, q_empty;
  logic [CMD_W-1:0] push_data, head_data;
  logic [31:0]      out_vertex;
  logic [1:0]       out_corner;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:         cfg.mode         <= cfg_data[1:0];
        REG_REVERSE:      cfg.reverse      <= cfg_data[0];
        REG_VERTEX_COUNT: cfg.vertex_count <= cfg_data;
        REG_BASE_VERTEX:  cfg.base_vertex  <= cfg_data;
      endcase
    end
  end

  tpa_front #(.INDEX_WIDTH(INDEX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_index  (s_axis_tdata),
    .in_end    (s_axis_tlast),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (push_data)
  );

  tpa_queue #(.WIDTH(CMD_W), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .head_data (head_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  tpa_back #(.INDEX_WIDTH(INDEX_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .head_data  (head_data),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_vertex (out_vertex),
    .out_corner (out_corner),
    .out_status (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_corner, out_vertex};

endmodule
